### rtl/dbc_pkg.sv
// Shared types, constants and helper functions for the dark blob centroid block.
// Used by the channel interfaces, the divider and the top level; depends on nothing.
package dbc_pkg;

  localparam int MAX_SIDE   = 1024;
  localparam int CNT_W      = $clog2(MAX_SIDE);
  localparam int COUNT_W    = 2 * CNT_W + 1;
  localparam int SUM_W      = 3 * CNT_W;
  localparam int STEP_W     = $clog2(CNT_W + 1);

  localparam int ORIGIN_W   = 10;
  localparam int CFG_SIDE_W = 11;
  localparam int THR_W      = 8;
  localparam int CHAN_W     = 8;
  localparam int COORD_W    = 12;
  localparam int COORD_MAX  = 2047;

  localparam int CMP_W   = (CNT_W + 1 > CFG_SIDE_W) ? CNT_W + 1 : CFG_SIDE_W;
  localparam int PLACE_W = ((CNT_W > ORIGIN_W) ? CNT_W : ORIGIN_W) + 1;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam int unsigned WIDTH_RST  = 1024;
  localparam int unsigned HEIGHT_RST = 1024;
  localparam int unsigned THR_RST    = 50;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] REG_LEFT   = 3'd0;
  localparam logic [2:0] REG_TOP    = 3'd1;
  localparam logic [2:0] REG_WIDTH  = 3'd2;
  localparam logic [2:0] REG_HEIGHT = 3'd3;
  localparam logic [2:0] REG_THRESH = 3'd4;

  typedef enum logic [2:0] {
    ST_ACC,
    ST_X_GO,
    ST_X_RUN,
    ST_Y_GO,
    ST_Y_RUN
  } dbc_state_e;

  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   dividend;
    logic [COUNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] quotient;
  } div_rsp_t;

  // Effective window side: zero acts as one, anything above MAX_SIDE clamps.
  function automatic logic [CMP_W-1:0] side_eff(input logic [CFG_SIDE_W-1:0] v);
    logic [CMP_W-1:0] ext;
    logic [CMP_W-1:0] res;
    ext = CMP_W'(v);
    priority if (ext == '0) begin
      res = CMP_W'(1);
    end else if (ext > CMP_W'(MAX_SIDE)) begin
      res = CMP_W'(MAX_SIDE);
    end else begin
      res = ext;
    end
    return res;
  endfunction

  // Mean offset plus origin, saturated to the coordinate range.
  function automatic logic signed [COORD_W-1:0] place(input logic [CNT_W-1:0] q,
                                                     input logic [ORIGIN_W-1:0] org);
    logic [PLACE_W-1:0] p;
    p = PLACE_W'(q) + PLACE_W'(org);
    if (p > PLACE_W'(COORD_MAX)) begin
      p = PLACE_W'(COORD_MAX);
    end
    return signed'(COORD_W'(p));
  endfunction

endpackage

### rtl/dbc_pix_if.sv
// Pixel channel: valid/ready handshake carrying one RGB pixel.
// Depends on dbc_pkg for the channel width.
interface dbc_pix_if;
  import dbc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

### rtl/dbc_res_if.sv
// Result channel: valid/ready handshake carrying one centroid result.
// Depends on dbc_pkg for the coordinate width.
interface dbc_res_if;
  import dbc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      found;
  logic signed [COORD_W-1:0] new_x;
  logic signed [COORD_W-1:0] new_y;
  logic signed [COORD_W-1:0] old_x;
  logic signed [COORD_W-1:0] old_y;

  modport source (output valid, found, new_x, new_y, old_x, old_y, input ready);
  modport sink   (input valid, found, new_x, new_y, old_x, old_y, output ready);
endinterface

### rtl/dbc_div.sv
// Shared restoring divider, one quotient bit per cycle, quotient known below MAX_SIDE.
// Depends on dbc_pkg for widths and the request/response structs.
module dbc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dbc_pkg::div_req_t req_i,
  output dbc_pkg::div_rsp_t rsp_o
);
  import dbc_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic [COUNT_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0]   quo_q, quo_d;
  logic [COUNT_W-1:0] dsr_q, dsr_d;

  logic [COUNT_W:0]   trial;
  logic               ge;
  logic               last;

  assign trial = {rem_q, quo_q[CNT_W-1]};
  assign ge    = trial >= {1'b0, dsr_q};
  assign last  = step_q == STEP_W'(CNT_W - 1);

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      // quotient fits in CNT_W bits, so the high part is already below the divisor
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = COUNT_W'(req_i.dividend >> CNT_W);
      quo_d  = req_i.dividend[CNT_W-1:0];
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d  = ge ? COUNT_W'(trial - {1'b0, dsr_q}) : COUNT_W'(trial);
      quo_d  = CNT_W'({quo_q, ge});
      step_d = step_q + STEP_W'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

### rtl/dark_blob_centroid_top.sv
// Dark blob centroid: one pixel per cycle accepted while no division runs and no result
// pends for a window's last pixel; such a last pixel with dark pixels triggers two divisions
// on one shared bit-serial divider, holding ready low until the result is registered.
// Windows without a dark pixel emit their result in the cycle after the last pixel.
// Async active-low reset: counters and sums clear, positions go to -1, registers to defaults.
module dark_blob_centroid_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dbc_pix_if.sink                       pix_i,
  dbc_res_if.source                     res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dbc_pkg::PADDR_W-1:0]   paddr,
  input  logic [dbc_pkg::PDATA_W-1:0]   pwdata,
  output logic [dbc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import dbc_pkg::*;

  // configuration
  logic [ORIGIN_W-1:0]   left_q, top_q;
  logic [CFG_SIDE_W-1:0] width_q, height_q;
  logic [THR_W-1:0]      thr_q;
  logic                  cfg_wr;
  logic [2:0]            cfg_idx;

  // sequencer
  dbc_state_e state_q, state_d;
  logic       pix_fire, res_fire;
  logic       pix_ready, div_start, div_sel_y, save_x, finish;

  // accumulation
  logic [CNT_W-1:0]   col_cnt_q, col_cnt_d, row_cnt_q, row_cnt_d;
  logic [COUNT_W-1:0] dark_cnt_q, dark_cnt_d, dark_cnt_add;
  logic [SUM_W-1:0]   col_sum_q, col_sum_d, col_sum_add;
  logic [SUM_W-1:0]   row_sum_q, row_sum_d, row_sum_add;
  logic [CMP_W-1:0]   w_eff, h_eff;
  logic               is_dark, row_last, col_last, win_last;

  // positions and result
  logic signed [COORD_W-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic signed [COORD_W-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic signed [COORD_W-1:0] nx, ny;
  logic [CNT_W-1:0]          qx_q, qx_d;
  logic                      out_valid_q, out_valid_d;
  logic                      emit;
  logic                      out_found_q, out_found_d;
  logic signed [COORD_W-1:0] out_nx_q, out_nx_d, out_ny_q, out_ny_d;
  logic signed [COORD_W-1:0] out_ox_q, out_ox_d, out_oy_q, out_oy_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  dbc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[PADDR_W-1:2];

  always_comb begin
    unique case (cfg_idx)
      REG_LEFT:   prdata = PDATA_W'(left_q);
      REG_TOP:    prdata = PDATA_W'(top_q);
      REG_WIDTH:  prdata = PDATA_W'(width_q);
      REG_HEIGHT: prdata = PDATA_W'(height_q);
      REG_THRESH: prdata = PDATA_W'(thr_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      top_q    <= '0;
      width_q  <= CFG_SIDE_W'(WIDTH_RST);
      height_q <= CFG_SIDE_W'(HEIGHT_RST);
      thr_q    <= THR_W'(THR_RST);
    end else if (cfg_wr) begin
      if (cfg_idx == REG_LEFT)   left_q   <= pwdata[ORIGIN_W-1:0];
      if (cfg_idx == REG_TOP)    top_q    <= pwdata[ORIGIN_W-1:0];
      if (cfg_idx == REG_WIDTH)  width_q  <= pwdata[CFG_SIDE_W-1:0];
      if (cfg_idx == REG_HEIGHT) height_q <= pwdata[CFG_SIDE_W-1:0];
      if (cfg_idx == REG_THRESH) thr_q    <= pwdata[THR_W-1:0];
    end
  end

  // ---------------- pixel decode ----------------
  assign w_eff    = side_eff(width_q);
  assign h_eff    = side_eff(height_q);
  assign row_last = (CMP_W'(row_cnt_q) + CMP_W'(1)) >= h_eff;
  assign col_last = (CMP_W'(col_cnt_q) + CMP_W'(1)) >= w_eff;
  assign win_last = row_last && col_last;
  assign is_dark  = (pix_i.red < thr_q) && (pix_i.green < thr_q) && (pix_i.blue < thr_q);

  assign dark_cnt_add = dark_cnt_q + COUNT_W'(is_dark);
  assign col_sum_add  = is_dark ? col_sum_q + SUM_W'(col_cnt_q) : col_sum_q;
  assign row_sum_add  = is_dark ? row_sum_q + SUM_W'(row_cnt_q) : row_sum_q;

  assign pix_fire = pix_i.valid && pix_i.ready;
  assign res_fire = res_o.valid && res_o.ready;

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ACC: begin
        if (pix_fire && win_last && (dark_cnt_add != '0)) state_d = ST_X_GO;
      end
      ST_X_GO:  state_d = ST_X_RUN;
      ST_X_RUN: begin
        if (div_rsp.done) state_d = ST_Y_GO;
      end
      ST_Y_GO:  state_d = ST_Y_RUN;
      ST_Y_RUN: begin
        if (div_rsp.done) state_d = ST_ACC;
      end
      default:  state_d = ST_ACC;
    endcase
  end

  always_comb begin
    // hold off a window's last pixel while the previous result is still pending
    pix_ready = (state_q == ST_ACC) && (!out_valid_q || !win_last);
    div_start = (state_q == ST_X_GO) || (state_q == ST_Y_GO);
    div_sel_y = state_q == ST_Y_GO;
    save_x    = (state_q == ST_X_RUN) && div_rsp.done;
    finish    = (state_q == ST_Y_RUN) && div_rsp.done;
  end

  assign pix_i.ready      = pix_ready;
  assign div_req.start    = div_start;
  assign div_req.dividend = div_sel_y ? row_sum_q : col_sum_q;
  assign div_req.divisor  = dark_cnt_q;

  // ---------------- datapath ----------------
  assign nx = place(qx_q, left_q);
  assign ny = place(div_rsp.quotient, top_q);

  always_comb begin
    col_cnt_d   = col_cnt_q;
    row_cnt_d   = row_cnt_q;
    dark_cnt_d  = dark_cnt_q;
    col_sum_d   = col_sum_q;
    row_sum_d   = row_sum_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    qx_d        = qx_q;
    emit        = 1'b0;
    out_found_d = out_found_q;
    out_nx_d    = out_nx_q;
    out_ny_d    = out_ny_q;
    out_ox_d    = out_ox_q;
    out_oy_d    = out_oy_q;

    if (pix_fire) begin
      dark_cnt_d = dark_cnt_add;
      col_sum_d  = col_sum_add;
      row_sum_d  = row_sum_add;
      if (!row_last) begin
        row_cnt_d = row_cnt_q + CNT_W'(1);
      end else begin
        row_cnt_d = '0;
        col_cnt_d = col_last ? '0 : col_cnt_q + CNT_W'(1);
      end
      if (win_last && (dark_cnt_add == '0)) begin
        // empty window: report not found, keep stored positions
        emit        = 1'b1;
        out_found_d = 1'b0;
        out_nx_d    = '1;
        out_ny_d    = '1;
        out_ox_d    = prev_x_q;
        out_oy_d    = prev_y_q;
        dark_cnt_d  = '0;
        col_sum_d   = '0;
        row_sum_d   = '0;
      end
    end

    if (save_x) qx_d = div_rsp.quotient;

    if (finish) begin
      emit        = 1'b1;
      out_found_d = 1'b1;
      out_nx_d    = nx;
      out_ny_d    = ny;
      out_ox_d    = cur_x_q;
      out_oy_d    = cur_y_q;
      prev_x_d    = cur_x_q;
      prev_y_d    = cur_y_q;
      cur_x_d     = nx;
      cur_y_d     = ny;
      dark_cnt_d  = '0;
      col_sum_d   = '0;
      row_sum_d   = '0;
    end

    out_valid_d = emit || (out_valid_q && !res_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACC;
      col_cnt_q   <= '0;
      row_cnt_q   <= '0;
      dark_cnt_q  <= '0;
      col_sum_q   <= '0;
      row_sum_q   <= '0;
      cur_x_q     <= '1;
      cur_y_q     <= '1;
      prev_x_q    <= '1;
      prev_y_q    <= '1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      col_cnt_q   <= col_cnt_d;
      row_cnt_q   <= row_cnt_d;
      dark_cnt_q  <= dark_cnt_d;
      col_sum_q   <= col_sum_d;
      row_sum_q   <= row_sum_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    qx_q        <= qx_d;
    out_found_q <= out_found_d;
    out_nx_q    <= out_nx_d;
    out_ny_q    <= out_ny_d;
    out_ox_q    <= out_ox_d;
    out_oy_q    <= out_oy_d;
  end

  assign res_o.valid = out_valid_q;
  assign res_o.found = out_found_q;
  assign res_o.new_x = out_nx_q;
  assign res_o.new_y = out_ny_q;
  assign res_o.old_x = out_ox_q;
  assign res_o.old_y = out_oy_q;

endmodule

### dv/dbc_centroid_checker.sv
// Checker for the dark blob centroid block: snoops the APB writes and both channels,
// keeps its own window accumulators and compares every result with the predicted one.
// Depends on dbc_pkg and on the dbc_pix_if / dbc_res_if channel interfaces.
module dbc_centroid_checker
  import dbc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  dbc_pix_if                 pix_mon,
  dbc_res_if                 res_mon,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  input  logic               pready,
  output int unsigned        pending_o,
  output int unsigned        results_o,
  output int unsigned        found_o,
  output int unsigned        errors_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                      found;
    logic signed [COORD_W-1:0] new_x;
    logic signed [COORD_W-1:0] new_y;
    logic signed [COORD_W-1:0] old_x;
    logic signed [COORD_W-1:0] old_y;
  } centroid_t;

  centroid_t expected_centroids[$];

  logic [ORIGIN_W-1:0]   cfg_left;
  logic [ORIGIN_W-1:0]   cfg_top;
  logic [CFG_SIDE_W-1:0] cfg_width;
  logic [CFG_SIDE_W-1:0] cfg_height;
  logic [THR_W-1:0]      cfg_thr;

  int unsigned               col_pos;
  int unsigned               row_pos;
  longint unsigned           dark_pixels;
  longint unsigned           col_total;
  longint unsigned           row_total;
  logic signed [COORD_W-1:0] cur_x;
  logic signed [COORD_W-1:0] cur_y;
  logic signed [COORD_W-1:0] prev_x;
  logic signed [COORD_W-1:0] prev_y;

  function automatic int unsigned clamp_side(logic [CFG_SIDE_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  function automatic logic signed [COORD_W-1:0] blob_coord(longint unsigned total,
                                                          longint unsigned count,
                                                          logic [ORIGIN_W-1:0] origin);
    longint unsigned pos;
    pos = total / count + origin;
    if (pos > COORD_MAX) pos = COORD_MAX;
    return COORD_W'(pos);
  endfunction

  task automatic apply_write(logic [2:0] idx, logic [PDATA_W-1:0] value);
    case (idx)
      REG_LEFT:   cfg_left   = value[ORIGIN_W-1:0];
      REG_TOP:    cfg_top    = value[ORIGIN_W-1:0];
      REG_WIDTH:  cfg_width  = value[CFG_SIDE_W-1:0];
      REG_HEIGHT: cfg_height = value[CFG_SIDE_W-1:0];
      REG_THRESH: cfg_thr    = value[THR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic accumulate_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                                  logic [CHAN_W-1:0] b);
    int unsigned cols;
    int unsigned rows;
    centroid_t   res;
    cols = clamp_side(cfg_width);
    rows = clamp_side(cfg_height);
    if (r < cfg_thr && g < cfg_thr && b < cfg_thr) begin
      dark_pixels++;
      col_total += col_pos;
      row_total += row_pos;
    end
    // A counter at or past the last index wraps, even after a size change.
    if (row_pos + 1 < rows) begin
      row_pos++;
      return;
    end
    row_pos = 0;
    if (col_pos + 1 < cols) begin
      col_pos++;
      return;
    end
    col_pos = 0;
    if (dark_pixels != 0) begin
      res.found = 1'b1;
      res.new_x = blob_coord(col_total, dark_pixels, cfg_left);
      res.new_y = blob_coord(row_total, dark_pixels, cfg_top);
      prev_x = cur_x;
      prev_y = cur_y;
      cur_x  = res.new_x;
      cur_y  = res.new_y;
    end else begin
      res.found = 1'b0;
      res.new_x = -1;
      res.new_y = -1;
    end
    res.old_x = prev_x;
    res.old_y = prev_y;
    expected_centroids.push_back(res);
    dark_pixels = 0;
    col_total   = 0;
    row_total   = 0;
  endtask

  task automatic check_result();
    centroid_t want;
    results_o++;
    if (res_mon.found) found_o++;
    if (expected_centroids.size() == 0) begin
      $error("unexpected result: found=%0d new=(%0d,%0d) old=(%0d,%0d)", res_mon.found,
             res_mon.new_x, res_mon.new_y, res_mon.old_x, res_mon.old_y);
      errors_o++;
      return;
    end
    want = expected_centroids.pop_front();
    if (res_mon.found !== want.found) begin
      $error("found: expected %0d, got %0d", want.found, res_mon.found);
      errors_o++;
    end
    if (res_mon.new_x !== want.new_x) begin
      $error("new_x: expected %0d, got %0d", want.new_x, res_mon.new_x);
      errors_o++;
    end
    if (res_mon.new_y !== want.new_y) begin
      $error("new_y: expected %0d, got %0d", want.new_y, res_mon.new_y);
      errors_o++;
    end
    if (res_mon.old_x !== want.old_x) begin
      $error("old_x: expected %0d, got %0d", want.old_x, res_mon.old_x);
      errors_o++;
    end
    if (res_mon.old_y !== want.old_y) begin
      $error("old_y: expected %0d, got %0d", want.old_y, res_mon.old_y);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_left    = '0;
      cfg_top     = '0;
      cfg_width   = CFG_SIDE_W'(WIDTH_RST);
      cfg_height  = CFG_SIDE_W'(HEIGHT_RST);
      cfg_thr     = THR_W'(THR_RST);
      col_pos     = 0;
      row_pos     = 0;
      dark_pixels = 0;
      col_total   = 0;
      row_total   = 0;
      cur_x       = -1;
      cur_y       = -1;
      prev_x      = -1;
      prev_y      = -1;
      expected_centroids.delete();
      pending_o   = 0;
      results_o   = 0;
      found_o     = 0;
      errors_o    = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        apply_write(paddr[4:2], pwdata);
      end
      // Check before predicting so a pixel never matches a result of the same edge.
      if (res_mon.valid && res_mon.ready) begin
        check_result();
      end
      if (pix_mon.valid && pix_mon.ready) begin
        accumulate_pixel(pix_mon.red, pix_mon.green, pix_mon.blue);
      end
      pending_o = expected_centroids.size();
    end
  end

endmodule

### dv/tb_dark_blob_centroid_top.sv
// Testbench top for the dark blob centroid block: drives pixels and APB writes,
// throttles the result channel and reports the verdict of dbc_centroid_checker.
// Depends on dbc_pkg, the channel interfaces, the checker and the RTL top level.
module tb_dark_blob_centroid_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dbc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500_000;
  localparam int unsigned SETTLE_TIME  = 40;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned PHASE_PIXELS = 200;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  int unsigned pending;
  int unsigned results;
  int unsigned found_cnt;
  int unsigned errors;

  int unsigned cycle_count = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned hold_reqs = 0;
  int unsigned holds_done = 0;
  int unsigned pixels_sent = 0;
  int unsigned settings_done = 0;
  logic [THR_W-1:0] pix_thr;

  dbc_pix_if pix_ch ();
  dbc_res_if res_ch ();

  dark_blob_centroid_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_ch),
    .res_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  dbc_centroid_checker centroid_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_mon   (pix_ch),
    .res_mon   (res_ch),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .pready    (pready),
    .pending_o (pending),
    .results_o (results),
    .found_o   (found_cnt),
    .errors_o  (errors)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: random back-pressure, plus a long hold-off when one is requested.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != holds_done) begin
        holds_done = hold_reqs;
        repeat (HOLD_CYCLES) begin
          res_ch.ready <= 1'b0;
          @(posedge clk_i);
        end
      end
      res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  task automatic offer_pixel(logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                             logic [CHAN_W-1:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.red   <= r;
    pix_ch.green <= g;
    pix_ch.blue  <= b;
    @(posedge clk_i);
    while (!pix_ch.ready) @(posedge clk_i);
    pixels_sent++;
  endtask

  task automatic apb_write(logic [2:0] idx, logic [PDATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic program_window(logic [ORIGIN_W-1:0] col0, logic [ORIGIN_W-1:0] row0,
                                logic [CFG_SIDE_W-1:0] width, logic [CFG_SIDE_W-1:0] height,
                                logic [THR_W-1:0] thr);
    apb_write(REG_LEFT, PDATA_W'(col0));
    apb_write(REG_TOP, PDATA_W'(row0));
    apb_write(REG_WIDTH, PDATA_W'(width));
    apb_write(REG_HEIGHT, PDATA_W'(height));
    apb_write(REG_THRESH, PDATA_W'(thr));
    pix_thr = thr;
    settings_done++;
  endtask

  // Drop valid, wait for every pending result, then let the divider go quiet.
  task automatic settle();
    pix_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_TIME) @(posedge clk_i);
  endtask

  function automatic logic [ORIGIN_W-1:0] pick_origin();
    int unsigned sel;
    sel = $urandom_range(7);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    return ORIGIN_W'($urandom);
  endfunction

  function automatic logic [CFG_SIDE_W-1:0] pick_side();
    if ($urandom_range(11) == 0) return '0;
    return CFG_SIDE_W'($urandom_range(1, 6));
  endfunction

  function automatic logic [THR_W-1:0] pick_thr();
    int unsigned sel;
    sel = $urandom_range(11);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel == 2) return THR_W'(THR_RST);
    return THR_W'($urandom_range(1, 255));
  endfunction

  // Dark pixels below the current threshold for about 45 percent of offers (none at a zero threshold), else anything.
  task automatic offer_random_pixel();
    logic [23:0] px;
    if (pix_thr != 0 && $urandom_range(99) < 45) begin
      px = {8'($urandom_range(int'(pix_thr) - 1)), 8'($urandom_range(int'(pix_thr) - 1)),
            8'($urandom_range(int'(pix_thr) - 1))};
    end else begin
      px = 24'($urandom);
    end
    offer_pixel(px[23:16], px[15:8], px[7:0]);
  endtask

  initial begin
    int unsigned budget;
    int unsigned cols;
    int unsigned rows;
    int unsigned npix;
    logic [CFG_SIDE_W-1:0] width;
    logic [CFG_SIDE_W-1:0] height;
    bit held;

    rst_ni       = 1'b0;
    pix_ch.valid = 1'b0;
    pix_ch.red   = '0;
    pix_ch.green = '0;
    pix_ch.blue  = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    pix_thr      = THR_W'(THR_RST);
    held         = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (SETTLE_TIME) @(posedge clk_i);

    // Threshold edges at 49/50, all-zero and all-ones pixels.
    program_window(10'd0, 10'd0, 11'd2, 11'd2, 8'd50);
    offer_pixel(8'd0, 8'd0, 8'd0);
    offer_pixel(8'd49, 8'd49, 8'd49);
    offer_pixel(8'd50, 8'd0, 8'd0);
    offer_pixel(8'd255, 8'd255, 8'd255);
    // Window without any dark pixel.
    offer_pixel(8'd0, 8'd50, 8'd0);
    offer_pixel(8'd0, 8'd0, 8'd50);
    offer_pixel(8'd255, 8'd0, 8'd0);
    offer_pixel(8'd128, 8'd128, 8'd128);
    settle();
    // Largest origin and threshold with single-pixel windows.
    program_window(10'd1023, 10'd1023, 11'd1, 11'd1, 8'd255);
    offer_pixel(8'd254, 8'd254, 8'd254);
    offer_pixel(8'd255, 8'd254, 8'd254);
    settle();
    // Zero sizes act as one; a zero threshold makes nothing dark.
    program_window(10'd0, 10'd0, 11'd0, 11'd0, 8'd0);
    offer_pixel(8'd0, 8'd0, 8'd0);
    settle();
    // Shrink the height in the middle of a window.
    program_window(10'd5, 10'd7, 11'd3, 11'd3, 8'd255);
    repeat (5) offer_pixel(8'd0, 8'd0, 8'd0);
    settle();
    apb_write(REG_HEIGHT, PDATA_W'(11'd1));
    offer_pixel(8'd0, 8'd0, 8'd0);
    offer_pixel(8'd0, 8'd0, 8'd0);
    settle();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          src_idle_pct  = 22;
          sink_idle_pct = 81;
        end
        1: begin
          src_idle_pct  = 81;
          sink_idle_pct = 22;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      if (ph == 2) begin
        // Widest window; an oversized width clamps to the maximum.
        settle();
        program_window(pick_origin(), pick_origin(), 11'd2047, 11'd1, pick_thr());
        repeat (MAX_SIDE) offer_random_pixel();
      end
      budget = PHASE_PIXELS;
      while (budget > 0) begin
        settle();
        width  = pick_side();
        height = pick_side();
        program_window(pick_origin(), pick_origin(), width, height, pick_thr());
        cols = (width == 0) ? 1 : width;
        rows = (height == 0) ? 1 : height;
        npix = $urandom_range(1, 8) * cols * rows;
        // Leave a partial window behind now and then for the next setting.
        if (cols * rows > 1 && $urandom_range(3) == 0) begin
          npix += $urandom_range(1, cols * rows - 1);
        end
        for (int i = 0; i < npix; i++) begin
          if (ph == 1 && !held && budget < PHASE_PIXELS / 2) begin
            hold_reqs++;
            held = 1'b1;
          end
          offer_random_pixel();
          if (budget > 0) budget--;
        end
      end
    end

    settle();
    $display("Drove %0d pixels under %0d register settings, with idling on both sides,",
             pixels_sent, settings_done);
    $display("and checked %0d results, %0d of them with a dark blob.", results, found_cnt);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/dbc_pkg.sv
rtl/dbc_pix_if.sv
rtl/dbc_res_if.sv
rtl/dbc_div.sv
rtl/dark_blob_centroid_top.sv
dv/dbc_centroid_checker.sv
dv/tb_dark_blob_centroid_top.sv
